// File: rtl/core/assert_macros.svh
// Assertion macros, included by png_row_unfilter_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk while i_rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/core/pru_pkg.sv
// Package for the PNG row unfilter: sizes, codes, stage types and helper functions.
`default_nettype none
package pru_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_BPP     = 4;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;

    localparam int BYTE_W    = 8;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int BPP_W     = 3;
    localparam int COL_W     = $clog2(STORE_DEPTH);
    localparam int STRIDE_W  = COL_W + 1;
    localparam int PHASE_W   = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Row filter types
    localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
    localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BPP          = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1;
    localparam logic [BPP_W-1:0]    BPP_RST    = 3'd4;

    // Control carried with a sample byte into the reconstruction stage
    typedef struct packed {
        logic [BYTE_W-1:0]  filter;
        logic [PHASE_W-1:0] phase;
        logic               has_left;
        logic               first_row;
    } t_s1_ctrl;

    // col mod 3, one base-4 digit a step
    function automatic logic [1:0] mod3(input logic [COL_W-1:0] col);
        logic [COL_W:0] ext;
        logic [1:0]     acc;
        logic [2:0]     sum;
        ext = {1'b0, col};
        acc = 2'd0;
        for (int k = (COL_W + 1) / 2 - 1; k >= 0; k--) begin
            sum = {1'b0, acc} + {1'b0, ext[2*k +: 2]};
            acc = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
        end
        return acc;
    endfunction

    // Byte phase inside a pixel: col mod bpp, bpp already in 1..4
    function automatic logic [PHASE_W-1:0] col_phase(input logic [COL_W-1:0] col,
                                                     input logic [BPP_W-1:0] bpp);
        logic [PHASE_W-1:0] ph;
        unique case (bpp)
            3'd2:    ph = PHASE_W'(col[0]);
            3'd3:    ph = PHASE_W'(mod3(col));
            3'd4:    ph = PHASE_W'(col[1:0]);
            default: ph = '0;
        endcase
        return ph;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/png_row_unfilter_top.sv
// Top level of the PNG row unfilter: config registers, row control, line RAM and output stage.
`default_nettype none
`include "assert_macros.svh"
// PNG scanline reconstruction. The slave stream carries the inflated image
// one byte per item: per row a filter type byte (no output), then
// image_width * bytes_per_pixel filtered samples. Each sample comes out on
// the master stream reconstructed with none/sub/up/average/Paeth (types
// above 4 act as none), with tlast on the last byte of a row and tuser on
// the last byte of the image; row counting restarts after image_height
// rows. Throughput is one byte per clock with no stalls of its own, filter
// bytes included; a sample passes through stage 1 and then the output
// register before it is presented on the master stream. Stage 1 waits for
// the line RAM (one port write, one port read), whose registered read
// supplies the byte above; the write of a row lands before the next row can
// read it, so no interlock is needed. The line RAM has no
// clearing pass: the first row of each image never reads it. Registers
// (APB, 32-bit data): 0x0 image_width, 0x4 image_height, 0x8
// bytes_per_pixel. Out-of-range values are clamped (width 0 acts as 1, above
// 2048 as 2048; bpp 0 as 1, above 4 as 4; height 0 as 1). Write them only
// while no item is in flight; a change inside a row applies at once.
module png_row_unfilter_top
    import pru_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // [7:0] filtered_byte
    // Output stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [7:0]        o_m_tdata,   // [7:0] pixel_byte
    output logic                   o_m_tlast,   // row_last
    output logic                   o_m_tuser,   // [0] image_last
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // ---------------- configuration ----------------
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [BPP_W-1:0]    r_bpp;
    logic [1:0]          reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_bpp    <= BPP_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                REG_BPP:          r_bpp    <= pwdata[BPP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_height);
            REG_BPP:          prdata = APB_DW'(r_bpp);
            default:          prdata = '0;
        endcase
    end

    // Clamp to the supported range
    logic [WIDTH_W-1:0]  eff_width;
    logic [BPP_W-1:0]    eff_bpp;
    logic [HEIGHT_W-1:0] eff_height;
    logic [STRIDE_W-1:0] stride;

    always_comb begin
        priority if (r_width == '0) begin
            eff_width = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_width = r_width;
        end
        priority if (r_bpp == '0) begin
            eff_bpp = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_BPP)) begin
            eff_bpp = BPP_W'(MAX_BPP);
        end else begin
            eff_bpp = r_bpp;
        end
        eff_height = (r_height == '0) ? HEIGHT_W'(1) : r_height;
        // Widen both factors first: a full row of 2048 four-byte pixels needs 14 bits
        stride     = STRIDE_W'(eff_width) * STRIDE_W'(eff_bpp);
    end

    // ---------------- row control (accept stage) ----------------
    logic                r_await;
    logic [BYTE_W-1:0]   r_filter;
    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;

    logic                advance, accept, sample_acc, row_end, img_end, out_free;
    logic [STRIDE_W-1:0] col_inc;
    logic [HEIGHT_W-1:0] row_inc;

    // Stage 1 holds one sample while its above byte is read
    logic                r_s1_valid;
    t_s1_ctrl            r_s1_ctrl;
    logic [BYTE_W-1:0]   r_s1_raw;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_s1_rlast;
    logic                r_s1_ilast;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;
    logic                r_out_last;
    logic                r_out_user;

    logic [BYTE_W-1:0]   above_q;
    logic [BYTE_W-1:0]   val;
    logic                s1_fire;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = !r_s1_valid || out_free;
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && o_s_tready;
    assign sample_acc = accept && !r_await;
    assign s1_fire    = r_s1_valid && out_free;

    assign col_inc = {1'b0, r_col} + STRIDE_W'(1);
    assign row_end = col_inc >= stride;
    assign row_inc = r_row + HEIGHT_W'(1);
    assign img_end = (row_inc >= eff_height) || (row_inc == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_filter <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (accept) begin
            if (r_await) begin
                // Filter type byte: latch it, start the row
                r_filter <= i_s_tdata;
                r_await  <= 1'b0;
                r_col    <= '0;
            end else if (row_end) begin
                r_await <= 1'b1;
                r_col   <= '0;
                r_row   <= img_end ? '0 : row_inc;
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= sample_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_s1_raw            <= i_s_tdata;
            r_s1_col            <= r_col;
            r_s1_ctrl.filter    <= r_filter;
            r_s1_ctrl.phase     <= col_phase(r_col, eff_bpp);
            r_s1_ctrl.has_left  <= {1'b0, r_col} >= STRIDE_W'(eff_bpp);
            r_s1_ctrl.first_row <= (r_row == '0);
            r_s1_rlast          <= row_end;
            r_s1_ilast          <= row_end && img_end;
        end
    end

    // ---------------- line store ----------------
    pru_line_ram #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (BYTE_W)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (val),
        .i_rd_en   (sample_acc),
        .i_rd_addr (r_col),
        .o_rd_data (above_q)
    );

    // ---------------- reconstruction ----------------
    pru_predictor u_predictor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s1_fire),
        .i_ctrl    (r_s1_ctrl),
        .i_raw     (r_s1_raw),
        .i_above_q (above_q),
        .o_val     (val)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= val;
            r_out_last <= r_s1_rlast;
            r_out_user <= r_s1_ilast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    // ---------------- assertions ----------------
    // A blocked stage 1 keeps its sample and takes no new input
    `ASSERT_CLK(a_s1_hold, (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_col)), "stage 1 sample lost while stalled")
    `ASSERT_CLK(a_no_accept_stall, (r_s1_valid && !out_free) |-> !o_s_tready, "input accepted while stage 1 is stalled")
    // The byte after a row's last sample is a filter type
    `ASSERT_CLK(a_row_end_filter, (sample_acc && row_end) |=> r_await, "row end did not rearm filter byte")
    // Image end only on a row end
    `ASSERT_CLK(a_img_on_row, (r_out_valid && r_out_user) |-> r_out_last, "image end without row end")

endmodule
`default_nettype wire

// File: rtl/core/pru_line_ram.sv
// Simple dual-port RAM with a registered read, holds the previous row.
`default_nettype none
module pru_line_ram #(
    parameter int DEPTH  = 8192,
    parameter int DATA_W = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/pru_predictor.sv
// Reconstruction stage: neighbor histories, sub/up/average/Paeth predictor, final add.
`default_nettype none
module pru_predictor
    import pru_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_s1_ctrl          i_ctrl,
    input  wire logic [BYTE_W-1:0] i_raw,
    input  wire logic [BYTE_W-1:0] i_above_q,
    output logic      [BYTE_W-1:0] o_val
);

    logic [BYTE_W-1:0] r_left_hist [MAX_BPP];
    logic [BYTE_W-1:0] r_ul_hist   [MAX_BPP];

    logic [BYTE_W-1:0] left, above, upleft, pred, paeth_sel;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W:0]   pa, pb;
    logic [BYTE_W+1:0] ab_sum, c2, pc;

    always_comb begin
        // Zero outside the image
        left   = i_ctrl.has_left ? r_left_hist[i_ctrl.phase] : '0;
        above  = i_ctrl.first_row ? '0 : i_above_q;
        upleft = (i_ctrl.has_left && !i_ctrl.first_row) ? r_ul_hist[i_ctrl.phase] : '0;

        avg_sum = {1'b0, left} + {1'b0, above};

        pa     = (above >= upleft) ? {1'b0, above} - {1'b0, upleft}
                                   : {1'b0, upleft} - {1'b0, above};
        pb     = (left >= upleft) ? {1'b0, left} - {1'b0, upleft}
                                  : {1'b0, upleft} - {1'b0, left};
        ab_sum = {2'b0, left} + {2'b0, above};
        c2     = {1'b0, upleft, 1'b0};
        pc     = (ab_sum >= c2) ? ab_sum - c2 : c2 - ab_sum;

        priority if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
            paeth_sel = left;
        end else if ({1'b0, pb} <= pc) begin
            paeth_sel = above;
        end else begin
            paeth_sel = upleft;
        end

        unique case (i_ctrl.filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth_sel;
            default:    pred = '0;
        endcase

        o_val = i_raw + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BPP; k++) begin
                r_left_hist[k] <= '0;
                r_ul_hist[k]   <= '0;
            end
        end else if (i_en) begin
            r_left_hist[i_ctrl.phase] <= o_val;
            r_ul_hist[i_ctrl.phase]   <= above;
        end
    end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for png_row_unfilter_top: a directed table, then random images.
module testbench;
    import pru_pkg::*;

    // Filter type codes that the package leaves out
    localparam logic [BYTE_W-1:0] FILT_NONE = 8'd0;
    localparam logic [BYTE_W-1:0] FILT_ODD  = 8'd5;    // first type above Paeth
    localparam logic [BYTE_W-1:0] FILT_TOP  = 8'hFF;

    localparam int ITEM_TARGET  = 1180;  // directed plus random items
    localparam int DRAIN_CYCLES = 6;     // stage 1 and output register plus margin
    // No handshake for this long means a hang: the worst quiet stretch of a
    // correct run is a register update or one sender gap plus one receiver
    // stall, both far below this limit.
    localparam int IDLE_LIMIT   = 2000;

    // One reconstructed byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
        logic              image_end;
    } t_pixel_res;

    typedef enum logic {STEP_REG, STEP_BYTE} t_step_kind;

    // One row of the directed table
    typedef struct packed {
        t_step_kind  kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        checked;   // use the typed-in result instead of the predictor
        t_pixel_res  want;
    } t_dir_step;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata  = '0;   // [7:0] filtered_byte
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [7:0]        o_m_tdata;         // [7:0] pixel_byte
    logic              o_m_tlast;         // row_last
    logic              o_m_tuser;         // [0] image_last
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    png_row_unfilter_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block: configuration, line store, neighbour history, counters
    logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RST;
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RST;
    logic [BPP_W-1:0]    cfg_bpp    = BPP_RST;
    logic [7:0]          prev_row    [STORE_DEPTH] = '{default: 8'h00};
    logic [7:0]          left_hist   [MAX_BPP]     = '{default: 8'h00};
    logic [7:0]          upleft_hist [MAX_BPP]     = '{default: 8'h00};
    int unsigned         col_pos    = 0;
    logic [15:0]         rows_done  = '0;
    logic [7:0]          cur_filter = FILT_NONE;
    bit                  filter_due = 1'b1;
    bit                  image_done = 1'b0;

    t_pixel_res pixel_q [$];     // reconstructed bytes still owed by the block
    t_dir_step  plan_q [$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         burst_left = 4;
    bit         steady     = 1'b0;  // sender without gaps for this phase
    logic [9:0] stall_tick = '0;
    logic [1:0] stall_mode = '0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [7:0] paeth_pick(input int a, input int b, input int c);
        int p, da, db, dc;
        p  = a + b - c;
        da = (p > a) ? p - a : a - p;
        db = (p > b) ? p - b : b - p;
        dc = (p > c) ? p - c : c - p;
        if (da <= db && da <= dc) return 8'(a);
        if (db <= dc) return 8'(b);
        return 8'(c);
    endfunction

    // Advance the shadow by one accepted byte; a filter type byte makes no result.
    task automatic reconstruct(input logic [7:0] raw, output bit made, output t_pixel_res res);
        int unsigned width, bpp, stride, col, ph;
        int          left, above, upleft, pred;
        made = 1'b0;
        res  = '0;
        if (filter_due) begin
            cur_filter = raw;
            filter_due = 1'b0;
            col_pos    = 0;
            return;
        end
        width  = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        bpp    = (cfg_bpp == 0) ? 1 : (cfg_bpp > MAX_BPP) ? MAX_BPP : cfg_bpp;
        stride = width * bpp;
        col    = col_pos;
        ph     = col % bpp;
        // neighbours outside the image read as zero
        left   = (col >= bpp) ? left_hist[ph] : 0;
        above  = (rows_done != 0 && col < STORE_DEPTH) ? prev_row[col] : 0;
        upleft = (col >= bpp && rows_done != 0) ? upleft_hist[ph] : 0;
        case (cur_filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = (left + above) / 2;
            FILT_PAETH: pred = paeth_pick(left, above, upleft);
            default:    pred = 0;
        endcase
        res.pixel       = 8'(raw + pred);
        upleft_hist[ph] = 8'(above);
        left_hist[ph]   = res.pixel;
        if (col < STORE_DEPTH) prev_row[col] = res.pixel;
        if (col + 1 >= stride) begin
            res.row_end = 1'b1;
            col_pos     = 0;
            filter_due  = 1'b1;
            rows_done   = rows_done + 16'd1;
            if (rows_done >= ((cfg_height == 0) ? 16'd1 : cfg_height) || rows_done == 0) begin
                res.image_end = 1'b1;
                rows_done     = '0;
                image_done    = 1'b1;
            end
        end else begin
            col_pos = col + 1;
        end
        made = 1'b1;
    endtask

    // Offer one item, wait for it to be taken, then maybe pause the sender.
    task automatic push_byte(input logic [7:0] value, input bit checked, input t_pixel_res typed);
        bit         made;
        t_pixel_res res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        reconstruct(value, made, res);
        if (made) pixel_q.insert(pixel_q.size(), checked ? typed : res);
        if (burst_left > 0) begin
            burst_left--;
        end else if (!steady) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Random byte fitting the stream position: a type byte or a sample.
    task automatic push_next();
        logic [7:0] value;
        if (filter_due) begin
            case ($urandom_range(0, 5))
                0:       value = FILT_NONE;
                1:       value = FILT_SUB;
                2:       value = FILT_UP;
                3:       value = FILT_AVG;
                4:       value = FILT_PAETH;
                default: value = 8'($urandom_range(FILT_ODD, 255));
            endcase
        end else begin
            case ($urandom_range(0, 7))
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom_range(0, 255));
            endcase
        end
        push_byte(value, 1'b0, '0);
    endtask

    // Drop valid and wait until every owed byte is out and the pipe is empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then read back; random junk rides above the register width.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            REG_IMAGE_WIDTH: begin
                mask      = 32'((1 << WIDTH_W) - 1);
                cfg_width = value[WIDTH_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                mask       = 32'((1 << HEIGHT_W) - 1);
                cfg_height = value[HEIGHT_W-1:0];
            end
            default: begin
                mask    = 32'((1 << BPP_W) - 1);
                cfg_bpp = value[BPP_W-1:0];
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & mask) | ($urandom() & ~mask);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask)) flag_mismatch("register readback", prdata, value & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic plan_reg(input logic [1:0] idx, input logic [31:0] value);
        t_dir_step s;
        s         = '0;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.value   = value;
        plan_q.insert(plan_q.size(), s);
    endtask

    task automatic plan_byte(input logic [7:0] value);
        t_dir_step s;
        s       = '0;
        s.kind  = STEP_BYTE;
        s.value = 32'(value);
        plan_q.insert(plan_q.size(), s);
    endtask

    task automatic plan_pixel(input logic [7:0] value, input logic [7:0] px,
                              input logic rl, input logic il);
        t_dir_step s;
        s         = '0;
        s.kind    = STEP_BYTE;
        s.value   = 32'(value);
        s.checked = 1'b1;
        s.want    = {px, rl, il};
        plan_q.insert(plan_q.size(), s);
    endtask

    // Receiver: a stall pattern that changes whenever the low byte of stall_tick
    // wraps; mode zero never stalls, so stretches of full throughput appear as well.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 10'd1;
        if (stall_tick[7:0] == 8'hFF) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    i_m_tready <= 1'b1;
            2'd1:    i_m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_m_tready <= (stall_tick[2:0] != 3'd7);
            default: i_m_tready <= stall_tick[3];
        endcase
    end

    // Compare each result taken from the block with the oldest one owed.
    always @(posedge i_clk) begin
        t_pixel_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                flag_mismatch("result with nothing pending", 32'(o_m_tdata), '0);
            end else begin
                want = pixel_q.pop_front();
                if (o_m_tdata !== want.pixel)
                    flag_mismatch("pixel_byte", 32'(o_m_tdata), 32'(want.pixel));
                if (o_m_tlast !== want.row_end)
                    flag_mismatch("row_last", 32'(o_m_tlast), 32'(want.row_end));
                if (o_m_tuser !== want.image_end)
                    flag_mismatch("image_last", 32'(o_m_tuser), 32'(want.image_end));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either stream for too long.
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_run = 0;
            else idle_run++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: rows of four bytes, one row per image.
        plan_byte(FILT_NONE);
        plan_pixel(8'h00, 8'h00, 1'b0, 1'b0);
        plan_pixel(8'hFF, 8'hFF, 1'b0, 1'b0);
        plan_byte(8'h80);
        plan_pixel(8'h7F, 8'h7F, 1'b1, 1'b1);
        // Two one-byte pixels per row, two rows per image: sub, Paeth, average and up.
        plan_reg(REG_IMAGE_WIDTH, 32'd2);
        plan_reg(REG_IMAGE_HEIGHT, 32'd2);
        plan_reg(REG_BPP, 32'd1);
        plan_byte(FILT_SUB);
        plan_pixel(8'hFF, 8'hFF, 1'b0, 1'b0);
        plan_pixel(8'h02, 8'h01, 1'b1, 1'b0);     // sum wraps past 255
        plan_byte(FILT_PAETH);
        plan_byte(8'h10);
        plan_byte(8'h20);
        plan_byte(FILT_AVG);
        plan_byte(8'h01);
        plan_byte(8'hFE);
        plan_byte(FILT_UP);
        plan_byte(8'h05);
        plan_byte(8'hF0);
        // Types above Paeth pass samples through unchanged.
        plan_byte(FILT_TOP);
        plan_pixel(8'h33, 8'h33, 1'b0, 1'b0);
        plan_pixel(8'h44, 8'h44, 1'b1, 1'b0);
        plan_byte(FILT_ODD);
        plan_pixel(8'h01, 8'h01, 1'b0, 1'b0);
        plan_pixel(8'h02, 8'h02, 1'b1, 1'b1);
        // Width and pixel size beyond range, height zero; then shrink the row
        // under the column count so that the next byte closes row and image.
        plan_reg(REG_IMAGE_WIDTH, 32'd4095);
        plan_reg(REG_IMAGE_HEIGHT, 32'd0);
        plan_reg(REG_BPP, 32'd7);
        plan_byte(FILT_NONE);
        plan_pixel(8'h01, 8'h01, 1'b0, 1'b0);
        plan_reg(REG_IMAGE_WIDTH, 32'd0);
        plan_reg(REG_BPP, 32'd0);
        plan_pixel(8'h02, 8'h02, 1'b1, 1'b1);
        // Tallest image, cut short by lowering the height below the row count.
        plan_reg(REG_IMAGE_HEIGHT, 32'd65535);
        plan_byte(FILT_NONE);
        plan_pixel(8'hAA, 8'hAA, 1'b1, 1'b0);
        plan_reg(REG_IMAGE_HEIGHT, 32'd0);
        plan_byte(FILT_NONE);
        plan_pixel(8'h55, 8'h55, 1'b1, 1'b1);

        foreach (plan_q[i]) begin
            if (plan_q[i].kind == STEP_REG) begin
                settle();
                write_reg(plan_q[i].reg_idx, plan_q[i].value);
            end else begin
                push_byte(plan_q[i].value[7:0], plan_q[i].checked, plan_q[i].want);
            end
        end

        // Random part: whole images with small random geometry. Each phase
        // starts on an image boundary, so the line store only grows where the
        // first row writes it before any row reads it.
        while (items_sent < ITEM_TARGET) begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 9) == 0) ?
                      $urandom_range(13, 40) : $urandom_range(0, 12));
            write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 4));
            write_reg(REG_BPP, $urandom_range(0, 7));
            repeat ($urandom_range(1, 3)) begin
                image_done = 1'b0;
                if ($urandom_range(0, 5) == 0) begin
                    // Change geometry inside the image: shrink the row or
                    // move the height, never grow the row.
                    repeat ($urandom_range(1, 8)) if (!image_done) push_next();
                    if (!image_done) begin
                        settle();
                        if ($urandom_range(0, 1) == 0)
                            write_reg(REG_IMAGE_WIDTH, $urandom_range(0, cfg_width));
                        else
                            write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 3));
                    end
                end
                while (!image_done) push_next();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
